/* rtl/core/hill_pkg.sv */
`default_nettype none

package hill_pkg;

   // block geometry
   localparam int ORDER_MAX = 4;
   localparam int LETTER_W  = 5;
   localparam int ACC_W     = 12;   // four products of 31 * 25 stay below 4096
   localparam int KEY_W     = ORDER_MAX * LETTER_W;

   // arithmetic constants
   localparam logic [4:0]  MODULUS    = 5'd26;
   localparam logic [6:0]  ASCII_A    = 7'd65;
   localparam logic [7:0]  ASCII_Z    = 8'd90;
   localparam logic [7:0]  ASCII_LA   = 8'd97;
   localparam logic [7:0]  ASCII_LZ   = 8'd122;
   localparam logic [4:0]  PAD_LETTER = 5'd23;   // 'X'
   localparam logic [11:0] RECIP_26   = 12'd2520; // floor(2^16 / 26)

   // configuration register indexes
   localparam logic [2:0] CSR_BLOCK_SIZE    = 3'd0;
   localparam logic [2:0] CSR_KEY_ROW_ZERO  = 3'd1;
   localparam logic [2:0] CSR_KEY_ROW_ONE   = 3'd2;
   localparam logic [2:0] CSR_KEY_ROW_TWO   = 3'd3;
   localparam logic [2:0] CSR_KEY_ROW_THREE = 3'd4;

   // configuration reset values: order 2, identity key
   localparam logic [2:0]       BLOCK_SIZE_RST = 3'd2;
   localparam logic [KEY_W-1:0] KEY_ROW0_RST   = 20'd1;
   localparam logic [KEY_W-1:0] KEY_ROW1_RST   = 20'd32;
   localparam logic [KEY_W-1:0] KEY_ROW2_RST   = 20'd1024;
   localparam logic [KEY_W-1:0] KEY_ROW3_RST   = 20'd32768;

   typedef logic [ORDER_MAX-1:0][KEY_W-1:0]    key_rows_type;
   typedef logic [ORDER_MAX-1:0][LETTER_W-1:0] letters_type;

   // one output row travelling down the cell chain
   typedef struct packed {
      logic              valid;
      logic [1:0]        row;
      logic [2:0]        order;
      letters_type       letters;
      logic [ACC_W-1:0]  acc;
      logic              run_last;
      logic              msg_done;
   } token_type;

   // clamp the raw block size to 1..ORDER_MAX
   function automatic logic [2:0] clip_order(input logic [2:0] raw);
      logic [2:0] n;
      n = raw;
      if (n == 3'd0) n = 3'd1;
      if (n > 3'(ORDER_MAX)) n = 3'(ORDER_MAX);
      return n;
   endfunction

endpackage

`default_nettype wire

/* rtl/core/hill_collect.sv */
`default_nettype none

module hill_collect (
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire logic                 req_tvalid,
   output logic                      req_tready,
   input  wire logic [7:0]           req_tdata,   // in_char
   input  wire logic                 req_tlast,   // msg_end
   input  wire logic                 advance,
   input  wire logic [2:0]           block_size,
   output hill_pkg::token_type       issue_tok
);

   logic [2:0]            fill_ff, fill_in;
   hill_pkg::letters_type letters_ff, letters_in, padded;
   logic                  pend_valid_ff;
   hill_pkg::letters_type pend_letters_ff;
   logic [2:0]            pend_order_ff;
   logic                  pend_last_ff;
   logic [1:0]            row_ff;

   logic [2:0] order;
   logic       accept, is_upper, is_lower, is_letter;
   logic [4:0] letter;
   logic       full, pad, emit, last_row;

   assign order    = hill_pkg::clip_order(block_size);
   assign last_row = ({1'b0, row_ff} == (pend_order_ff - 3'd1));

   // take an item while the issue slot is free or frees this cycle
   assign req_tready = !pend_valid_ff || (advance && last_row);
   assign accept     = req_tvalid && req_tready;

   // classify the byte and map it to 0..25
   assign is_upper  = (req_tdata >= 8'(hill_pkg::ASCII_A)) && (req_tdata <= hill_pkg::ASCII_Z);
   assign is_lower  = (req_tdata >= hill_pkg::ASCII_LA) && (req_tdata <= hill_pkg::ASCII_LZ);
   assign is_letter = is_upper || is_lower;

   always_comb begin
      logic [7:0] diff;
      diff   = is_lower ? (req_tdata - hill_pkg::ASCII_LA)
                        : (req_tdata - 8'(hill_pkg::ASCII_A));
      letter = diff[4:0];
   end

   // store the letter and decide whether a block goes out
   always_comb begin
      letters_in = letters_ff;
      if (is_letter) letters_in[fill_ff[1:0]] = letter;
      fill_in = is_letter ? (fill_ff + 3'd1) : fill_ff;
      full    = is_letter && (fill_in >= order);
      pad     = !full && req_tlast && (fill_in != 3'd0);
      emit    = full || pad;
      padded  = letters_in;
      for (int p = 0; p < hill_pkg::ORDER_MAX; p++) begin
         if (pad && (3'(p) >= fill_in) && (3'(p) < order)) padded[p] = hill_pkg::PAD_LETTER;
      end
   end

   // hold the current block
   always_ff @(posedge clock) begin
      if (reset) begin
         fill_ff <= 3'd0;
      end else if (accept) begin
         fill_ff <= emit ? 3'd0 : fill_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) letters_ff <= letters_in;
   end

   // issue slot: one row per advancing cycle
   always_ff @(posedge clock) begin
      if (reset) begin
         pend_valid_ff <= 1'b0;
         row_ff        <= 2'd0;
      end else if (accept && emit) begin
         pend_valid_ff <= 1'b1;
         row_ff        <= 2'd0;
      end else if (advance && pend_valid_ff) begin
         if (last_row) pend_valid_ff <= 1'b0;
         else          row_ff        <= row_ff + 2'd1;
      end
   end

   always_ff @(posedge clock) begin
      if (accept && emit) begin
         pend_letters_ff <= padded;
         pend_order_ff   <= order;
         pend_last_ff    <= req_tlast;
      end
   end

   // row token into the first cell
   always_comb begin
      issue_tok          = '0;
      issue_tok.valid    = pend_valid_ff;
      issue_tok.row      = row_ff;
      issue_tok.order    = pend_order_ff;
      issue_tok.letters  = pend_letters_ff;
      issue_tok.acc      = '0;
      issue_tok.run_last = last_row;
      issue_tok.msg_done = last_row && pend_last_ff;
   end

endmodule

`default_nettype wire

/* rtl/core/hill_cell.sv */
`default_nettype none

module hill_cell (
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic                  advance,
   input  wire logic [1:0]            cell_idx,
   input  wire hill_pkg::key_rows_type key_rows,
   input  wire hill_pkg::token_type   tok_i,
   output hill_pkg::token_type        tok_o
);

   hill_pkg::token_type tok_ff, tok_in;
   logic [4:0] key_entry;
   logic [9:0] prod;
   logic       use_col;

   // add this column's term: key[row][idx] * letter[idx]
   assign key_entry = key_rows[tok_i.row][5*cell_idx +: 5];
   assign prod      = 10'(key_entry) * 10'(tok_i.letters[cell_idx]);
   assign use_col   = tok_i.valid && ({1'b0, cell_idx} < tok_i.order);

   always_comb begin
      tok_in     = tok_i;
      tok_in.acc = tok_i.acc + (use_col ? hill_pkg::ACC_W'(prod) : '0);
   end

   // hand the row to the next cell
   always_ff @(posedge clock) begin
      if (reset) begin
         tok_ff.valid <= 1'b0;
      end else if (advance) begin
         tok_ff <= tok_in;
      end
   end

   assign tok_o = tok_ff;

endmodule

`default_nettype wire

/* rtl/core/hill_reduce.sv */
`default_nettype none

module hill_reduce (
   input  wire logic                clock,
   input  wire logic                reset,
   input  wire logic                advance,
   input  wire hill_pkg::token_type tok_i,
   output logic                     rsp_tvalid,
   output logic [7:0]               rsp_tdata,   // out_char, zero
   output logic                     rsp_tlast,   // run_last
   output logic                     rsp_tuser    // msg_done
);

   logic [23:0] qprod;
   logic [7:0]  quot;
   logic [12:0] qm;
   logic [12:0] rem_wide;
   logic [5:0]  rem;
   logic [4:0]  rem_fix;
   logic [6:0]  char_in;

   logic       valid_ff;
   logic [6:0] char_ff;
   logic       last_ff, done_ff;

   // acc mod 26 by reciprocal; quotient is low by at most one
   assign qprod    = 24'(tok_i.acc) * 24'(hill_pkg::RECIP_26);
   assign quot     = qprod[23:16];
   assign qm       = 13'(quot) * 13'(hill_pkg::MODULUS);
   assign rem_wide = 13'(tok_i.acc) - qm;
   assign rem      = rem_wide[5:0];
   always_comb begin
      logic [5:0] fixed;
      fixed   = (rem >= 6'(hill_pkg::MODULUS)) ? (rem - 6'(hill_pkg::MODULUS)) : rem;
      rem_fix = fixed[4:0];
   end
   assign char_in = hill_pkg::ASCII_A + 7'(rem_fix);

   // output register
   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (advance) begin
         valid_ff <= tok_i.valid;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         char_ff <= char_in;
         last_ff <= tok_i.run_last;
         done_ff <= tok_i.msg_done;
      end
   end

   assign rsp_tvalid = valid_ff;
   assign rsp_tdata  = {1'b0, char_ff};
   assign rsp_tlast  = last_ff;
   assign rsp_tuser  = done_ff;

endmodule

`default_nettype wire

/* rtl/core/hill_cipher_block_stream.sv */
// Hill cipher (mod 26) on a byte stream.
// req channel: one text byte per item in req_tdata, req_tlast marks the last
// byte of a message. Bytes that are not letters are dropped; letters of either
// case collect into blocks of block_size letters (1..4).
// rsp channel: each full block leaves as block_size upper-case letters, one
// per item, key row i times the block mod 26; rsp_tlast closes each block and
// rsp_tuser flags the last letter of a message. A partial block at message
// end is padded with X.
// csr port: csr_we/csr_addr/csr_wdata write block size (index 0) and the four
// key rows (indexes 1..4); write only while the block is idle.
// Path: the item that closes a block loads the issue slot; its rows pass the
// four cell registers and then the output register. Throughput: one item per
// cycle, except that an item which closes a block holds the single issue slot
// while its block_size rows go out, one row per advancing cycle, into a chain
// of four cells, each adding one column term, then the mod-26 output stage.
// Reset clears the fill count and the pipeline and loads block size 2 with the
// identity key. While a letter waits with rsp_tready low the chain and output
// register freeze; a busy slot keeps req_tready low until its last row issues.
`default_nettype none

module hill_cipher_block_stream (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_tvalid,
   output logic             req_tready,
   input  wire logic [7:0]  req_tdata,   // in_char
   input  wire logic        req_tlast,   // msg_end
   output logic             rsp_tvalid,
   input  wire logic        rsp_tready,
   output logic [7:0]       rsp_tdata,   // out_char, zero
   output logic             rsp_tlast,   // run_last
   output logic             rsp_tuser,   // msg_done
   input  wire logic        csr_we,
   input  wire logic [2:0]  csr_addr,
   input  wire logic [19:0] csr_wdata
);

   logic [2:0]             block_size_ff;
   hill_pkg::key_rows_type key_rows_ff;
   logic                   advance;
   hill_pkg::token_type    tok [0:hill_pkg::ORDER_MAX];

   // configuration registers
   always_ff @(posedge clock) begin
      if (reset) begin
         block_size_ff  <= hill_pkg::BLOCK_SIZE_RST;
         key_rows_ff[0] <= hill_pkg::KEY_ROW0_RST;
         key_rows_ff[1] <= hill_pkg::KEY_ROW1_RST;
         key_rows_ff[2] <= hill_pkg::KEY_ROW2_RST;
         key_rows_ff[3] <= hill_pkg::KEY_ROW3_RST;
      end else if (csr_we) begin
         unique case (csr_addr)
            hill_pkg::CSR_BLOCK_SIZE:    block_size_ff  <= csr_wdata[2:0];
            hill_pkg::CSR_KEY_ROW_ZERO:  key_rows_ff[0] <= csr_wdata;
            hill_pkg::CSR_KEY_ROW_ONE:   key_rows_ff[1] <= csr_wdata;
            hill_pkg::CSR_KEY_ROW_TWO:   key_rows_ff[2] <= csr_wdata;
            hill_pkg::CSR_KEY_ROW_THREE: key_rows_ff[3] <= csr_wdata;
            default: ;
         endcase
      end
   end

   // move the chain whenever the output register can take a row
   assign advance = !rsp_tvalid || rsp_tready;

   hill_collect u_collect (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tlast  (req_tlast),
      .advance    (advance),
      .block_size (block_size_ff),
      .issue_tok  (tok[0])
   );

   for (genvar i = 0; i < hill_pkg::ORDER_MAX; i++) begin : g_cell
      hill_cell u_cell (
         .clock    (clock),
         .reset    (reset),
         .advance  (advance),
         .cell_idx (2'(i)),
         .key_rows (key_rows_ff),
         .tok_i    (tok[i]),
         .tok_o    (tok[i+1])
      );
   end

   hill_reduce u_reduce (
      .clock      (clock),
      .reset      (reset),
      .advance    (advance),
      .tok_i      (tok[hill_pkg::ORDER_MAX]),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tdata  (rsp_tdata),
      .rsp_tlast  (rsp_tlast),
      .rsp_tuser  (rsp_tuser)
   );

endmodule

`default_nettype wire

/* rtl/core/hill_checker.sv */
`default_nettype none

module hill_checker (
   input wire logic        clock,
   input wire logic        reset,
   input wire logic        rsp_tvalid,
   input wire logic        rsp_tready,
   input wire logic [7:0]  rsp_tdata,
   input wire logic        rsp_tlast,
   input wire logic        rsp_tuser
);

   // reset empties the output stage
   a_reset_empty: assert property (@(posedge clock) reset |=> !rsp_tvalid)
      else $error("result valid right after reset");

   // a stalled item holds its payload
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata)
         && $stable(rsp_tlast) && $stable(rsp_tuser))
      else $error("stalled result changed");

   // message end only closes a block run
   a_done_last: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tuser |-> rsp_tlast)
      else $error("msg_done without run_last");

   // every cipher letter is upper-case ASCII
   a_char_range: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> (rsp_tdata >= 8'd65) && (rsp_tdata <= 8'd90))
      else $error("cipher letter out of range");

endmodule

bind hill_cipher_block_stream hill_checker u_checker (.*);

`default_nettype wire

/* sim/tb_top.sv */
`default_nettype none

module tb_top;

   localparam int IDLE_LIMIT = 2000;   // cycles without any item moving
   localparam int SETTLE     = 20;     // at least block latency plus one full block of rows
   localparam int LONG_HOLD  = 120;    // receiver hold-off that backs up the input
   localparam int RAND_PHASE = 42;     // items per random phase

   typedef struct {
      logic [7:0] ch;
      logic       fin;
   } text_item_type;

   typedef struct packed {
      logic [6:0] letter;
      logic       run_last;
      logic       msg_done;
   } cipher_letter_type;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [7:0]  req_tdata = 8'd0;   // in_char
   logic        req_tlast = 1'b0;   // msg_end
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic [7:0]  rsp_tdata;          // out_char, zero
   logic        rsp_tlast;          // run_last
   logic        rsp_tuser;          // msg_done
   logic        csr_we = 1'b0;
   logic [2:0]  csr_addr = 3'd0;
   logic [19:0] csr_wdata = 20'd0;

   hill_cipher_block_stream uut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tlast  (req_tlast),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tlast  (rsp_tlast),
      .rsp_tuser  (rsp_tuser),
      .csr_we     (csr_we),
      .csr_addr   (csr_addr),
      .csr_wdata  (csr_wdata)
   );

   // shadow of the cipher state and its registers
   logic [2:0]  order_reg;
   logic [19:0] key_reg [hill_pkg::ORDER_MAX];
   logic [4:0]  held [hill_pkg::ORDER_MAX];
   logic [2:0]  held_count;

   text_item_type     pending_bytes [$];
   cipher_letter_type cipher_q [$];

   int fail_count = 0;
   int idle_cycles = 0;
   int send_pct = 0;
   int recv_pct = 0;
   int send_gap = 0;
   int hold_left = 0;
   bit hold_req = 1'b0;
   bit req_fired = 1'b0;

   always begin
      #10 clock = 1'b1;
      #10 clock = 1'b0;
   end

   // mostly short gaps, now and then a long one
   function automatic int pick_gap(input int pct);
      if (pct == 0 || $urandom_range(0, 99) >= pct) return 0;
      if ($urandom_range(0, 7) == 0) return $urandom_range(12, 40);
      return $urandom_range(1, 3);
   endfunction

   function automatic int unsigned live_order();
      int unsigned n;
      n = order_reg;
      if (n == 0) n = 1;
      if (n > hill_pkg::ORDER_MAX) n = hill_pkg::ORDER_MAX;
      return n;
   endfunction

   // key times the held block, mod 26, one letter per row
   task automatic encrypt_block(input int unsigned n, input logic fin);
      int unsigned acc;
      cipher_letter_type c;
      for (int unsigned i = 0; i < n; i++) begin
         acc = 0;
         for (int unsigned j = 0; j < n; j++)
            acc += key_reg[i][5*j +: 5] * held[j];
         c.letter   = 7'(acc % hill_pkg::MODULUS + hill_pkg::ASCII_A);
         c.run_last = (i + 1 == n);
         c.msg_done = (i + 1 == n) && fin;
         cipher_q.insert(cipher_q.size(), c);
      end
      held_count = 3'd0;
   endtask

   task automatic predict_item(input logic [7:0] ch, input logic fin);
      int unsigned n;
      n = live_order();
      if ((ch >= 8'(hill_pkg::ASCII_A) && ch <= hill_pkg::ASCII_Z) ||
          (ch >= hill_pkg::ASCII_LA && ch <= hill_pkg::ASCII_LZ)) begin
         held[held_count[1:0]] = (ch >= hill_pkg::ASCII_LA) ? 5'(ch - hill_pkg::ASCII_LA)
                                                            : 5'(ch - 8'(hill_pkg::ASCII_A));
         held_count = held_count + 3'd1;
         if (held_count >= n) begin
            encrypt_block(n, fin);
            return;
         end
      end
      // pad a partial block with X at message end
      if (fin && held_count != 3'd0) begin
         for (int unsigned p = held_count; p < n; p++)
            held[p] = hill_pkg::PAD_LETTER;
         encrypt_block(n, 1'b1);
      end
   endtask

   // drive the input side: advance when the current item is taken
   always @(negedge clock) begin : drive_req
      text_item_type nxt;
      if (reset) begin
         req_tvalid <= 1'b0;
      end else if (!req_tvalid || req_fired) begin
         if (send_gap > 0) begin
            send_gap--;
            req_tvalid <= 1'b0;
         end else if (pending_bytes.size() != 0) begin
            nxt = pending_bytes.pop_front();
            req_tdata  <= nxt.ch;
            req_tlast  <= nxt.fin;
            req_tvalid <= 1'b1;
            send_gap = pick_gap(send_pct);
         end else begin
            req_tvalid <= 1'b0;
         end
      end
   end

   // drive the receiver's ready, with a long hold-off on request
   always @(negedge clock) begin : drive_rsp
      int stall;
      if (reset) begin
         rsp_tready <= 1'b0;
      end else if (hold_left > 0) begin
         hold_left--;
         rsp_tready <= 1'b0;
      end else if (hold_req) begin
         hold_req = 1'b0;
         hold_left = LONG_HOLD - 1;
         rsp_tready <= 1'b0;
      end else begin
         stall = pick_gap(recv_pct);
         if (stall > 0) begin
            hold_left = stall - 1;
            rsp_tready <= 1'b0;
         end else begin
            rsp_tready <= 1'b1;
         end
      end
   end

   // sample both channels, predict and check
   always @(posedge clock) begin : watch
      cipher_letter_type want;
      logic rsp_fired;
      if (reset) begin
         req_fired = 1'b0;
      end else begin
         req_fired = req_tvalid && req_tready;
         rsp_fired = rsp_tvalid && rsp_tready;
         if (req_fired) predict_item(req_tdata, req_tlast);
         if (rsp_fired) begin
            if (cipher_q.size() == 0) begin
               $error("item with nothing expected: out_char %0d", rsp_tdata);
               fail_count++;
            end else begin
               want = cipher_q.pop_front();
               if (rsp_tdata !== {1'b0, want.letter}) begin
                  $error("out_char expected %0d actual %0d", want.letter, rsp_tdata);
                  fail_count++;
               end
               if (rsp_tlast !== want.run_last) begin
                  $error("run_last expected %0d actual %0d", want.run_last, rsp_tlast);
                  fail_count++;
               end
               if (rsp_tuser !== want.msg_done) begin
                  $error("msg_done expected %0d actual %0d", want.msg_done, rsp_tuser);
                  fail_count++;
               end
            end
         end
         // watchdog
         if (req_fired || rsp_fired) idle_cycles = 0;
         else idle_cycles++;
         if (idle_cycles >= IDLE_LIMIT) begin
            $display("tb_top failed");
            $finish;
         end
      end
   end

   task automatic queue_item(input logic [7:0] ch, input logic fin);
      text_item_type t;
      t.ch  = ch;
      t.fin = fin;
      pending_bytes.insert(pending_bytes.size(), t);
   endtask

   // messages of random letters in both cases, mixed with raw noise bytes
   task automatic queue_random_text(input int count);
      int left;
      int len;
      logic [7:0] ch;
      logic fin;
      left = count;
      while (left > 0) begin
         if ($urandom_range(0, 4) == 0) begin
            queue_item(8'($urandom_range(0, 255)), $urandom_range(0, 5) == 0);
            left--;
         end else begin
            len = $urandom_range(1, 9);
            for (int k = 0; k < len && left > 0; k++) begin
               ch  = 8'($urandom_range(0, 1) ? hill_pkg::ASCII_LA : 8'(hill_pkg::ASCII_A))
                     + 8'($urandom_range(0, 25));
               fin = (k == len - 1);
               if (fin && $urandom_range(0, 2) == 0) ch = 8'($urandom_range(0, 255));
               queue_item(ch, fin);
               left--;
            end
         end
      end
   endtask

   task automatic begin_phase(input int s_pct, input int r_pct);
      @(posedge clock);
      send_pct = s_pct;
      recv_pct = r_pct;
   endtask

   // hold until every item is in and every letter out, then let the pipe drain
   task automatic wait_idle();
      while (pending_bytes.size() != 0 || req_tvalid || cipher_q.size() != 0)
         @(posedge clock);
      repeat (SETTLE) @(posedge clock);
   endtask

   task automatic csr_write(input logic [2:0] idx, input logic [19:0] val);
      @(negedge clock);
      csr_we    <= 1'b1;
      csr_addr  <= idx;
      csr_wdata <= val;
      if (idx == hill_pkg::CSR_BLOCK_SIZE) order_reg = val[2:0];
      else if (idx <= hill_pkg::CSR_KEY_ROW_THREE)
         key_reg[2'(idx - hill_pkg::CSR_KEY_ROW_ZERO)] = val;
   endtask

   task automatic csr_close();
      @(negedge clock);
      csr_we <= 1'b0;
   endtask

   task automatic load_key(input logic [19:0] r0, input logic [19:0] r1,
                           input logic [19:0] r2, input logic [19:0] r3);
      csr_write(hill_pkg::CSR_KEY_ROW_ZERO, r0);
      csr_write(hill_pkg::CSR_KEY_ROW_ONE, r1);
      csr_write(hill_pkg::CSR_KEY_ROW_TWO, r2);
      csr_write(hill_pkg::CSR_KEY_ROW_THREE, r3);
   endtask

   initial begin
      logic [2:0] orders [7];
      orders = '{3'd4, 3'd3, 3'd1, 3'd7, 3'd2, 3'd0, 3'd4};
      order_reg  = hill_pkg::BLOCK_SIZE_RST;
      key_reg[0] = hill_pkg::KEY_ROW0_RST;
      key_reg[1] = hill_pkg::KEY_ROW1_RST;
      key_reg[2] = hill_pkg::KEY_ROW2_RST;
      key_reg[3] = hill_pkg::KEY_ROW3_RST;
      for (int i = 0; i < hill_pkg::ORDER_MAX; i++) held[i] = 5'd0;
      held_count = 3'd0;
      repeat (4) @(posedge clock);
      @(negedge clock) reset <= 1'b0;

      // reset settings: order 2, identity key; letter bounds, both cases, padding
      begin_phase(20, 20);
      queue_item("A", 1'b0);
      queue_item("Z", 1'b0);
      queue_item("a", 1'b0);
      queue_item("z", 1'b0);
      queue_item(8'h40, 1'b0);
      queue_item(8'h5B, 1'b0);
      queue_item(8'h60, 1'b0);
      queue_item(8'h7B, 1'b0);
      queue_item(8'h00, 1'b0);
      queue_item(8'hFF, 1'b0);
      queue_item("M", 1'b0);
      queue_item("?", 1'b1);   // pad partial block at message end
      queue_item(" ", 1'b1);   // message end with empty block
      queue_item("H", 1'b0);
      queue_item("i", 1'b1);   // end on the byte that completes a block
      queue_item("q", 1'b1);
      wait_idle();

      // largest order with all-31 key, then lower the order mid-block
      csr_write(hill_pkg::CSR_BLOCK_SIZE, 20'd4);
      load_key(20'hFFFFF, 20'hFFFFF, 20'hFFFFF, 20'hFFFFF);
      csr_close();
      begin_phase(0, 0);
      queue_item("a", 1'b0);
      queue_item("b", 1'b0);
      queue_item("c", 1'b0);
      wait_idle();
      csr_write(hill_pkg::CSR_BLOCK_SIZE, 20'd2);
      csr_close();
      begin_phase(0, 0);
      queue_item("D", 1'b0);
      wait_idle();

      // zero key; order zero reads as one; writes past the last index drop
      csr_write(hill_pkg::CSR_BLOCK_SIZE, 20'd4);
      load_key(20'd0, 20'd0, 20'd0, 20'd0);
      csr_close();
      begin_phase(10, 10);
      queue_item("x", 1'b0);
      queue_item("y", 1'b0);
      queue_item("z", 1'b0);
      wait_idle();
      csr_write(hill_pkg::CSR_BLOCK_SIZE, 20'd0);
      csr_write(3'(hill_pkg::CSR_KEY_ROW_THREE + 1), 20'($urandom));
      csr_write(3'(hill_pkg::CSR_KEY_ROW_THREE + 3), 20'($urandom));
      csr_close();
      begin_phase(10, 10);
      queue_item("#", 1'b1);   // held letters already fill the order
      queue_item("K", 1'b1);
      wait_idle();

      // back-pressure: receiver holds off while the sender keeps offering
      csr_write(hill_pkg::CSR_BLOCK_SIZE, 20'd1);
      load_key(20'($urandom), 20'($urandom), 20'($urandom), 20'($urandom));
      csr_close();
      begin_phase(0, 0);
      hold_req = 1'b1;
      queue_random_text(40);
      wait_idle();

      // random phases over several orders and keys
      for (int ph = 0; ph < 7; ph++) begin
         if (orders[ph] == 3'd7)
            csr_write(hill_pkg::CSR_BLOCK_SIZE, {17'($urandom), orders[ph]});
         else
            csr_write(hill_pkg::CSR_BLOCK_SIZE, {17'd0, orders[ph]});
         load_key(20'($urandom), 20'($urandom), 20'($urandom), 20'($urandom));
         csr_close();
         case (ph % 3)
            0: begin_phase(0, 0);
            1: begin_phase(25, 25);
            default: begin_phase(50, 40);
         endcase
         queue_random_text(RAND_PHASE);
         wait_idle();
      end

      repeat (SETTLE) @(posedge clock);
      if (cipher_q.size() != 0) begin
         $error("%0d expected letters never arrived", cipher_q.size());
         fail_count++;
      end
      if (fail_count == 0)
         $display("tb_top passed");
      else
         $display("tb_top failed");
      $finish;
   end

endmodule

`default_nettype wire
